### hw/rtl/trie_letter_step_unit_macros.svh
// ----------------------------------------------------------------------------
// Trie letter step assertion macros
// Shared assertion shorthands for the trie letter step unit.
// ----------------------------------------------------------------------------
`ifndef TRIE_LETTER_STEP_UNIT_MACROS_SVH
`define TRIE_LETTER_STEP_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TLSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tlsu_pkg.sv
// ----------------------------------------------------------------------------
// Trie letter step package
// Operation codes and table entry layouts shared by the unit and its input channel.
// ----------------------------------------------------------------------------
package tlsu_pkg;

  typedef enum logic [1:0] {
    OP_WRITE_NODE  = 2'd0,
    OP_WRITE_CHILD = 2'd1,
    OP_RESTART     = 2'd2,
    OP_STEP        = 2'd3
  } tlsu_op_e;

  // One node of the flattened trie.
  typedef struct packed {
    logic [8:0]  child_count;
    logic [11:0] child_start;
    logic [15:0] result_count;
    logic [15:0] result_start;
  } node_entry_t;

  // One child slot: its letter and the node it leads to.
  typedef struct packed {
    logic [7:0]  letter;
    logic [11:0] target;
  } child_entry_t;

  typedef struct packed {
    logic [15:0] count;
    logic [15:0] start;
  } tlsu_span_t;

endpackage

### hw/rtl/tlsu_in_if.sv
// ----------------------------------------------------------------------------
// Trie letter step input channel
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
interface tlsu_in_if import tlsu_pkg::*; ();

  logic        valid;
  logic        ready;
  tlsu_op_e    op;
  logic [11:0] addr;
  logic [7:0]  letter;
  logic [8:0]  child_count;
  logic [11:0] child_start;
  logic [15:0] entry_result_count;
  logic [15:0] entry_result_start;
  logic [11:0] child_target;

  modport source (
    output valid, op, addr, letter, child_count, child_start,
           entry_result_count, entry_result_start, child_target,
    input  ready
  );

  modport sink (
    input  valid, op, addr, letter, child_count, child_start,
           entry_result_count, entry_result_start, child_target,
    output ready
  );

endinterface

### hw/rtl/tlsu_out_if.sv
// ----------------------------------------------------------------------------
// Trie letter step output channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface tlsu_out_if ();

  logic        valid;
  logic        ready;
  logic [15:0] result_count;
  logic [15:0] result_start;
  logic        advanced;

  modport source (
    output valid, result_count, result_start, advanced,
    input  ready
  );

  modport sink (
    input  valid, result_count, result_start, advanced,
    output ready
  );

endinterface

### hw/rtl/tlsu_ram.sv
// ----------------------------------------------------------------------------
// Trie letter step RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module tlsu_ram #(
  parameter int WIDTH = 53,
  parameter int DEPTH = 4096
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/trie_letter_step_unit.sv
// ----------------------------------------------------------------------------
// Trie letter step unit
// Incremental prefix search over a flattened trie held in two on-chip RAMs.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Item contents
// -------  ---  --------------------------------------------------------------
// in_i     in   op, addr, letter, child_count, child_start, entry_result_count,
//               entry_result_start, child_target
// out_o    out  result_count, result_start, advanced (one per input item)
//
// A letter step is a binary search of the current node's children, with at
// most 9 probes for up to 511 children: each probe is one read of the child
// RAM followed by a compare, and the node RAM is read once before the search
// and, on a match inside the table, once after it. Reset clears the current
// node to the root and the reported span to zero; the RAMs come up undefined
// and need no clearing pass. The unit works on one item at a time. A finished
// result sits in the output register while the next item is accepted and
// worked on, so a stalled sink only holds the unit when a second result is
// ready to be delivered.
//
`include "trie_letter_step_unit_macros.svh"

module trie_letter_step_unit import tlsu_pkg::*; #(
  parameter int NODE_DEPTH  = 4096,
  parameter int CHILD_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tlsu_in_if.sink     in_i,
  tlsu_out_if.source  out_o
);

  localparam int NAW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int CAW = (CHILD_DEPTH > 1) ? $clog2(CHILD_DEPTH) : 1;
  localparam int NW  = $bits(node_entry_t);
  localparam int CW  = $bits(child_entry_t);

  // Sequencer states. The search alternates between issuing a child read
  // and comparing its letter.
  typedef enum logic [2:0] {
    S_IDLE,
    S_NODE,
    S_PROBE,
    S_CMP,
    S_SPAN,
    S_EMIT
  } state_e;

  state_e      state_q, state_d;
  tlsu_op_e    op_q, op_d;
  logic [7:0]  letter_q, letter_d;
  logic [11:0] pos_q, pos_d;
  logic [12:0] lo_q, lo_d;
  logic [12:0] hi_q, hi_d;
  logic [12:0] mid_q, mid_d;
  logic        adv_q, adv_d;
  tlsu_span_t  span_q, span_d;
  logic        out_valid_q, out_valid_d;
  tlsu_span_t  out_span_q, out_span_d;
  logic        out_adv_q, out_adv_d;

  // RAM ports.
  logic           node_we, node_re;
  logic [NAW-1:0] node_waddr, node_raddr;
  logic [NW-1:0]  node_wdata, node_rdata;
  logic           child_we, child_re;
  logic [CAW-1:0] child_waddr, child_raddr;
  logic [CW-1:0]  child_wdata, child_rdata;

  node_entry_t  node_rd;
  child_entry_t child_rd;
  logic [31:0]  in_addr_ext;
  logic [31:0]  pos_ext;
  logic [31:0]  target_ext;
  logic [31:0]  mid_ext;
  logic [12:0]  kid_end;
  logic [13:0]  mid_sum;
  logic         in_fire;

  assign node_rd     = node_entry_t'(node_rdata);
  assign child_rd    = child_entry_t'(child_rdata);
  assign in_addr_ext = 32'(in_i.addr);
  assign pos_ext     = 32'(pos_q);
  assign target_ext  = 32'(child_rd.target);
  assign kid_end     = 13'(node_rd.child_start) + 13'(node_rd.child_count);
  assign mid_sum     = 14'(lo_q) + 14'(hi_q);
  assign in_fire     = in_i.valid && in_i.ready;

  assign node_waddr  = in_addr_ext[NAW-1:0];
  assign child_waddr = in_addr_ext[CAW-1:0];
  assign node_wdata  = NW'(node_entry_t'{
                         child_count:  in_i.child_count,
                         child_start:  in_i.child_start,
                         result_count: in_i.entry_result_count,
                         result_start: in_i.entry_result_start});
  assign child_wdata = CW'(child_entry_t'{letter: in_i.letter,
                                          target: in_i.child_target});

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    letter_d    = letter_q;
    pos_d       = pos_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    adv_d       = adv_q;
    span_d      = span_q;
    out_valid_d = out_valid_q;
    out_span_d  = out_span_q;
    out_adv_d   = out_adv_q;
    node_we     = 1'b0;
    node_re     = 1'b0;
    node_raddr  = '0;
    child_we    = 1'b0;
    child_re    = 1'b0;
    child_raddr = '0;
    mid_ext     = 32'(mid_d);

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d     = in_i.op;
          letter_d = in_i.letter;
          adv_d    = 1'b0;
          unique case (in_i.op)
            OP_WRITE_NODE: begin
              node_we = (in_addr_ext < 32'(NODE_DEPTH));
              state_d = S_EMIT;
            end
            OP_WRITE_CHILD: begin
              child_we = (in_addr_ext < 32'(CHILD_DEPTH));
              state_d  = S_EMIT;
            end
            OP_RESTART: begin
              pos_d   = '0;
              node_re = 1'b1;
              state_d = S_SPAN;
            end
            OP_STEP: begin
              // A current node outside the table has no children.
              if (pos_ext < 32'(NODE_DEPTH)) begin
                node_re    = 1'b1;
                node_raddr = pos_ext[NAW-1:0];
                state_d    = S_NODE;
              end else begin
                state_d = S_EMIT;
              end
            end
          endcase
        end
      end

      S_NODE: begin
        // The searched range runs over the node's child slots, clipped to the child table's end.
        lo_d = {1'b0, node_rd.child_start};
        if (32'(kid_end) > 32'(CHILD_DEPTH)) begin
          hi_d = 13'(CHILD_DEPTH);
        end else begin
          hi_d = kid_end;
        end
        state_d = S_PROBE;
      end

      S_PROBE: begin
        if (lo_q < hi_q) begin
          mid_d       = mid_sum[13:1];
          mid_ext     = 32'(mid_d);
          child_re    = 1'b1;
          child_raddr = mid_ext[CAW-1:0];
          state_d     = S_CMP;
        end else begin
          state_d = S_EMIT;
        end
      end

      S_CMP: begin
        if (child_rd.letter == letter_q) begin
          adv_d = 1'b1;
          pos_d = child_rd.target;
          if (target_ext < 32'(NODE_DEPTH)) begin
            node_re    = 1'b1;
            node_raddr = target_ext[NAW-1:0];
            state_d    = S_SPAN;
          end else begin
            span_d  = '0;
            state_d = S_EMIT;
          end
        end else begin
          if (letter_q > child_rd.letter) begin
            lo_d = mid_q + 13'd1;
          end else begin
            hi_d = mid_q;
          end
          state_d = S_PROBE;
        end
      end

      S_SPAN: begin
        span_d.count = node_rd.result_count;
        span_d.start = node_rd.result_start;
        state_d      = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_span_d  = span_q;
          out_adv_d   = adv_q;
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_WRITE_NODE;
      letter_q    <= '0;
      pos_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      adv_q       <= 1'b0;
      span_q      <= '0;
      out_valid_q <= 1'b0;
      out_span_q  <= '0;
      out_adv_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      letter_q    <= letter_d;
      pos_q       <= pos_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      mid_q       <= mid_d;
      adv_q       <= adv_d;
      span_q      <= span_d;
      out_valid_q <= out_valid_d;
      out_span_q  <= out_span_d;
      out_adv_q   <= out_adv_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_count = out_span_q.count;
  assign out_o.result_start = out_span_q.start;
  assign out_o.advanced     = out_adv_q;

  tlsu_ram #(
    .WIDTH (NW),
    .DEPTH (NODE_DEPTH)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  tlsu_ram #(
    .WIDTH (CW),
    .DEPTH (CHILD_DEPTH)
  ) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (child_waddr),
    .wdata_i (child_wdata),
    .re_i    (child_re),
    .raddr_i (child_raddr),
    .rdata_o (child_rdata)
  );

  // Only a letter step can set the advanced flag.
  `TLSU_ASSERT_NOW(a_adv_only_step, clk_i, rst_ni, (state_q == S_EMIT && adv_q), (op_q == OP_STEP), "advanced set for an item that is not a letter step")

  // Every probe lies inside the live search range.
  `TLSU_ASSERT_NOW(a_mid_in_range, clk_i, rst_ni, (state_q == S_CMP), (mid_q >= lo_q && mid_q < hi_q), "search probe outside the live range")

  // Table writes leave the search state alone.
  `TLSU_ASSERT_NEXT(a_write_keeps_state, clk_i, rst_ni, (in_fire && (in_i.op == OP_WRITE_NODE || in_i.op == OP_WRITE_CHILD)), ($stable(span_q) && $stable(pos_q)), "table write changed the search state")

  // A restart always loads the root's span.
  `TLSU_ASSERT_NOW(a_restart_root, clk_i, rst_ni, (state_q == S_SPAN && op_q == OP_RESTART), (pos_q == 12'd0), "restart did not return to the root")

endmodule
